// File: rtl/core/tmprof_pkg.sv
`default_nettype none

package tmprof_pkg;

  localparam int DEF_TICKS_PER_SECOND = 1000;
  localparam int DEF_TICK_WIDTH = 24;

  localparam int CFG_W = 24;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY = 1'd1;
  localparam logic [CFG_W-1:0] ACCEL_RESET = 24'd65536;
  localparam logic [CFG_W-1:0] VELOCITY_RESET = 24'd32768;

  localparam int POS_W = 31;
  localparam int SEG_W = 2;
  localparam int QW = 32;
  localparam logic [POS_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [SEG_W-1:0] SEG_ACCEL = 2'd0;
  localparam logic [SEG_W-1:0] SEG_CRUISE = 2'd1;
  localparam logic [SEG_W-1:0] SEG_DECEL = 2'd2;
  localparam logic [SEG_W-1:0] SEG_DONE = 2'd3;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_TRI_ACC,
    KIND_TRI_DEC,
    KIND_TRAP_ACC,
    KIND_CRUISE,
    KIND_TRAP_DEC,
    KIND_DONE
  } kind_t;

  typedef struct packed {
    logic  vld;
    logic  sat;
    kind_t kind;
  } div_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/tmprof_if.sv
`default_nettype none

interface tmprof_tick_if #(
  parameter int TICK_WIDTH = tmprof_pkg::DEF_TICK_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [TICK_WIDTH-1:0] tick_index;

  modport source (output valid, output tick_index, input ready);
  modport sink (input valid, input tick_index, output ready);
endinterface

interface tmprof_result_if;
  logic                            valid;
  logic                            ready;
  logic [tmprof_pkg::POS_W-1:0]    position_q30;
  logic [tmprof_pkg::SEG_W-1:0]    segment;

  modport source (output valid, output position_q30, output segment, input ready);
  modport sink (input valid, input position_q30, input segment, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tmprof_cfg.sv
`default_nettype none

module tmprof_cfg #(
  parameter int TICKS_PER_SECOND = tmprof_pkg::DEF_TICKS_PER_SECOND,
  localparam int FW = $clog2(TICKS_PER_SECOND + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tmprof_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tmprof_pkg::CFG_W-1:0]       cfg_data,
  output logic [tmprof_pkg::CFG_W-1:0]            accel,
  output logic [tmprof_pkg::CFG_W-1:0]            velocity,
  output logic                                    ready,
  output logic                                    tri_shape,
  output logic                                    vzero,
  output logic [FW+23:0]                          vf,
  output logic [FW+23:0]                          fa,
  output logic [FW+47:0]                          fvv,
  output logic [FW+48:0]                          rhs,
  output logic [tmprof_pkg::QW-1:0]               h
);

  localparam int QW = tmprof_pkg::QW;
  localparam int START = QW + 3;
  localparam int LOAD = START - 1;
  localparam int CW = $clog2(START + 1);
  localparam int RW = FW + 49;
  localparam int DW = FW + 48;
  localparam logic [FW-1:0] F_C = FW'(TICKS_PER_SECOND);

  logic [CW-1:0]   cnt;
  logic [47:0]     vv;
  logic [39:0]     a16;
  logic [QW-2:0]   hrem;
  logic [QW-1:0]   hnlo;
  logic [QW-1:0]   hq;
  logic [QW-1:0]   htrial;
  logic            hge;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= tmprof_pkg::ACCEL_RESET;
      velocity <= tmprof_pkg::VELOCITY_RESET;
      cnt <= CW'(START);
    end else if (cfg_we) begin
      case (cfg_index)
        tmprof_pkg::REG_ACCEL: accel <= cfg_data;
        tmprof_pkg::REG_VELOCITY: velocity <= cfg_data;
        default: ;
      endcase
      cnt <= CW'(START);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  // derived terms, settled while cnt runs
  always_ff @(posedge clk) begin
    vv <= 48'(velocity) * 48'(velocity);
    a16 <= {accel, 16'd0};
    vzero <= (velocity == '0);
    vf <= (FW+24)'(velocity) * (FW+24)'(F_C);
    fa <= (FW+24)'(accel) * (FW+24)'(F_C);
    tri_shape <= (vv >= 48'(a16));
    fvv <= DW'(vv) * DW'(F_C);
    rhs <= RW'(F_C) * (RW'(a16) + RW'(vv));
  end

  // ramp distance vv * 2^15 / accel, one quotient bit per cycle
  assign htrial = {hrem, hnlo[QW-1]};
  assign hge = (htrial >= QW'(accel));

  always_ff @(posedge clk) begin
    if (cnt == CW'(LOAD)) begin
      hrem <= vv[47:17];
      hnlo <= {vv[16:0], 15'd0};
    end else if (cnt < CW'(LOAD) && cnt >= CW'(2)) begin
      hrem <= hge ? (QW-1)'(htrial - QW'(accel)) : htrial[QW-2:0];
      hnlo <= {hnlo[QW-2:0], 1'b0};
      hq <= {hq[QW-2:0], hge};
    end
  end

  assign h = hq;
  assign ready = (cnt == '0);

endmodule

`default_nettype wire

// File: rtl/core/tmprof_div.sv
`default_nettype none

module tmprof_div #(
  parameter int NW = 91,
  parameter int DW = 58
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire tmprof_pkg::div_ctl_t   in_ctl,
  input  wire logic [NW-1:0]          in_n,
  input  wire logic [DW-1:0]          in_d,
  output tmprof_pkg::div_ctl_t        out_ctl,
  output logic [tmprof_pkg::QW-1:0]   out_q
);

  localparam int QW = tmprof_pkg::QW;

  tmprof_pkg::div_ctl_t ctl [1:QW];
  logic [DW-1:0]        rem [1:QW];
  logic [DW-1:0]        dv  [1:QW];
  logic [QW-1:0]        nlo [1:QW];
  logic [QW-1:0]        q   [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    tmprof_pkg::div_ctl_t cur_ctl;
    logic [DW-1:0]        cur_rem;
    logic [DW-1:0]        cur_d;
    logic [QW-1:0]        cur_nlo;
    logic [QW-1:0]        cur_q;
    logic [DW:0]          trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign cur_ctl = in_ctl;
      assign cur_rem = in_n[QW+DW-1:QW];
      assign cur_d = in_d;
      assign cur_nlo = in_n[QW-1:0];
      assign cur_q = '0;
    end else begin : g_next
      assign cur_ctl = ctl[k];
      assign cur_rem = rem[k];
      assign cur_d = dv[k];
      assign cur_nlo = nlo[k];
      assign cur_q = q[k];
    end

    assign trial = {cur_rem, cur_nlo[QW-1]};
    assign ge = (trial >= {1'b0, cur_d});

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1] <= '0;
      end else if (en) begin
        ctl[k+1] <= cur_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DW'(trial - {1'b0, cur_d}) : trial[DW-1:0];
        dv[k+1] <= cur_d;
        nlo[k+1] <= {cur_nlo[QW-2:0], 1'b0};
        q[k+1] <= {cur_q[QW-2:0], ge};
      end
    end
  end

  assign out_ctl = ctl[QW];
  assign out_q = ctl[QW].sat ? '1 : q[QW];

endmodule

`default_nettype wire

// File: rtl/core/trapezoidal_motion_profile_unit.sv
`default_nettype none

// Normalized trapezoidal move from 0 to 1, evaluated per tick.
// tick (sink): one request carries tick_index; the profile is evaluated at
//   (tick_index + 1) / TICKS_PER_SECOND seconds.
// result (source): position_q30 (Q1.30, 0 to 1) and segment (accelerate,
//   cruise, decelerate, done). One result per request, in request order.
// cfg_we / cfg_index / cfg_data: index 0 acceleration, index 1 peak
//   velocity, both Q8.16. Write only while no request is in flight.
// Throughput: one request per cycle while tick.ready is high. A request
//   passes six front stages, the 32-stage quotient pipeline and three back
//   stages.
// After reset or any register write, tick.ready stays low while the derived
//   terms and the serial ramp-distance division settle.
// Reset: synchronous, clears all valid bits and loads the default registers.
// A stalled receiver freezes the whole pipeline; nothing is lost or repeated,
//   and with the output register full tick.ready drops.
module trapezoidal_motion_profile_unit #(
  parameter int TICKS_PER_SECOND = tmprof_pkg::DEF_TICKS_PER_SECOND,
  parameter int TICK_WIDTH = tmprof_pkg::DEF_TICK_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  tmprof_tick_if.sink                             tick,
  tmprof_result_if.source                         result,
  input  wire logic                               cfg_we,
  input  wire logic [tmprof_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tmprof_pkg::CFG_W-1:0]       cfg_data
);

  localparam int QW = tmprof_pkg::QW;
  localparam int POS_W = tmprof_pkg::POS_W;
  localparam int FW = $clog2(TICKS_PER_SECOND + 1);
  localparam int TTW = TICK_WIDTH + 1;
  localparam int VTW = (TICK_WIDTH + 25 > FW + 18) ? TICK_WIDTH + 25 : FW + 18;
  localparam int TAW = TICK_WIDTH + 25;
  localparam int HIW = VTW - 24;
  localparam int TAHI = TAW - 24;
  localparam int XW = FW + 17;
  localparam int VAW = VTW + 24;
  localparam int ATW = TAW + TTW;
  localparam int RW = FW + 49;
  localparam int DW = FW + 48;
  localparam int NW = FW + 81;
  localparam longint unsigned FL = TICKS_PER_SECOND;
  localparam logic [VTW-1:0] F16 = VTW'(FL << 16);
  localparam logic [VTW-1:0] F17 = VTW'(FL << 17);
  localparam logic [DW-1:0] F_SQ = DW'(FL * FL);
  localparam logic [DW-1:0] F_SQ8 = DW'(8 * FL * FL);
  localparam logic [QW-1:0] R_ONE = QW'(64'd1 << (QW - 1));

  logic [tmprof_pkg::CFG_W-1:0] accel;
  logic [tmprof_pkg::CFG_W-1:0] velocity;
  logic                         cfg_rdy;
  logic                         tri_shape;
  logic                         vzero;
  logic [FW+23:0]               vf;
  logic [FW+23:0]               fa;
  logic [DW-1:0]                fvv;
  logic [RW-1:0]                rhs;
  logic [QW-1:0]                h;

  logic adv;

  logic                s1_vld;
  logic [TTW-1:0]      s1_t;
  logic                s2_vld;
  logic [TTW-1:0]      s2_t;
  logic [VTW-1:0]      s2_vt;
  logic [TAW-1:0]      s2_ta;
  logic                s3_vld;
  logic [47:0]         s3_vta_lo;
  logic [HIW+23:0]     s3_vta_hi;
  logic [24+TTW-1:0]   s3_att_lo;
  logic [TAHI+TTW-1:0] s3_att_hi;
  logic                s3_c16;
  logic                s3_c17;
  logic                s3_cta;
  logic [XW-1:0]       s3_x;
  logic [VTW-1:0]      s2_e;
  logic                s4_vld;
  logic [VAW-1:0]      s4_vta;
  logic [ATW-1:0]      s4_att;
  logic [2*XW-1:0]     s4_xx;
  logic                s4_c16;
  logic                s4_c17;
  logic                s4_cta;
  logic                s5_vld;
  tmprof_pkg::kind_t   s5_kind;
  tmprof_pkg::kind_t   kind_next;
  logic [RW-1:0]       s5_d;
  logic [NW-1:0]       s5_cnum;
  logic [ATW-1:0]      s5_att;
  logic [2*XW-1:0]     s5_xx;
  tmprof_pkg::div_ctl_t s6_ctl;
  logic [NW-1:0]       s6_n;
  logic [DW-1:0]       s6_d;
  logic [NW-1:0]       n_sel;
  logic [DW-1:0]       d_sel;
  logic                dec_sat;

  tmprof_pkg::div_ctl_t dctl;
  logic [QW-1:0]        dq;
  logic [QW-1:0]        r_clip;
  tmprof_pkg::div_ctl_t p1_ctl;
  logic [QW-1:0]        p1_q;
  logic [2*QW-1:0]      p1_rr;
  tmprof_pkg::div_ctl_t p2_ctl;
  logic [QW-1:0]        p2_q;
  logic [2*QW-1:0]      p2_prod;
  logic                 p3_vld;
  logic [POS_W-1:0]     p3_pos;
  logic [1:0]           p3_seg;
  logic [POS_W-1:0]     pos_next;
  logic [1:0]           seg_next;
  logic [POS_W-1:0]     drop;
  logic [POS_W-1:0]     q_clip;

  tmprof_cfg #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .accel(accel),
    .velocity(velocity),
    .ready(cfg_rdy),
    .tri_shape(tri_shape),
    .vzero(vzero),
    .vf(vf),
    .fa(fa),
    .fvv(fvv),
    .rhs(rhs),
    .h(h)
  );

  assign adv = !p3_vld || result.ready;
  assign tick.ready = adv && cfg_rdy;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_ctl <= '0;
      p1_ctl <= '0;
      p2_ctl <= '0;
      p3_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= tick.valid && cfg_rdy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_ctl <= '{vld: s5_vld, sat: (n_sel[NW-1:QW] >= (NW-QW)'(d_sel)) || dec_sat,
                  kind: s5_kind};
      p1_ctl <= dctl;
      p2_ctl <= p1_ctl;
      p3_vld <= p2_ctl.vld;
    end
  end

  assign s2_e = F17 - s2_vt;

  // front stages: products and segment tests
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t <= TTW'(tick.tick_index) + TTW'(1);
      s2_t <= s1_t;
      s2_vt <= VTW'(s1_t) * VTW'(velocity);
      s2_ta <= TAW'(s1_t) * TAW'(accel);
      s3_vta_lo <= 48'(s2_vt[23:0]) * 48'(accel);
      s3_vta_hi <= (HIW+24)'(s2_vt[VTW-1:24]) * (HIW+24)'(accel);
      s3_att_lo <= (24+TTW)'(s2_ta[23:0]) * (24+TTW)'(s2_t);
      s3_att_hi <= (TAHI+TTW)'(s2_ta[TAW-1:24]) * (TAHI+TTW)'(s2_t);
      s3_c16 <= s2_vt < F16;
      s3_c17 <= s2_vt < F17;
      s3_cta <= (FW+TAW+24)'(s2_ta) < (FW+TAW+24)'(vf);
      s3_x <= (s2_vt < F16) ? s2_vt[XW-1:0] : s2_e[XW-1:0];
      s4_vta <= VAW'(s3_vta_lo) + (VAW'(s3_vta_hi) << 24);
      s4_att <= ATW'(s3_att_lo) + (ATW'(s3_att_hi) << 24);
      s4_xx <= (2*XW)'(s3_x) * (2*XW)'(s3_x);
      s4_c16 <= s3_c16;
      s4_c17 <= s3_c17;
      s4_cta <= s3_cta;
      s5_kind <= kind_next;
      s5_d <= rhs - RW'(s4_vta);
      s5_cnum <= (NW'(s4_vta) << 1) - NW'(fvv);
      s5_att <= s4_att;
      s5_xx <= s4_xx;
      s6_n <= n_sel;
      s6_d <= d_sel;
    end
  end

  always_comb begin
    if (vzero) begin
      kind_next = tmprof_pkg::KIND_ZERO;
    end else if (tri_shape) begin
      if (s4_c16) begin
        kind_next = tmprof_pkg::KIND_TRI_ACC;
      end else if (s4_c17) begin
        kind_next = tmprof_pkg::KIND_TRI_DEC;
      end else begin
        kind_next = tmprof_pkg::KIND_DONE;
      end
    end else if (s4_cta) begin
      kind_next = tmprof_pkg::KIND_TRAP_ACC;
    end else if (s4_c16) begin
      kind_next = tmprof_pkg::KIND_CRUISE;
    end else if ((RW+VAW)'(s4_vta) < (RW+VAW)'(rhs)) begin
      kind_next = tmprof_pkg::KIND_TRAP_DEC;
    end else begin
      kind_next = tmprof_pkg::KIND_DONE;
    end
  end

  // dividend and divisor for the quotient pipeline
  always_comb begin
    dec_sat = 1'b0;
    case (s5_kind)
      tmprof_pkg::KIND_TRI_ACC, tmprof_pkg::KIND_TRI_DEC: begin
        n_sel = NW'(s5_xx);
        d_sel = F_SQ8;
      end
      tmprof_pkg::KIND_TRAP_ACC: begin
        n_sel = NW'(s5_att) << 13;
        d_sel = F_SQ;
      end
      tmprof_pkg::KIND_CRUISE: begin
        n_sel = s5_cnum << 13;
        d_sel = DW'(fa);
      end
      tmprof_pkg::KIND_TRAP_DEC: begin
        n_sel = NW'(s5_d) << 31;
        d_sel = fvv;
        dec_sat = (s5_d >= RW'(fvv));
      end
      default: begin
        n_sel = '0;
        d_sel = F_SQ;
      end
    endcase
  end

  tmprof_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .en(adv),
    .in_ctl(s6_ctl),
    .in_n(s6_n),
    .in_d(s6_d),
    .out_ctl(dctl),
    .out_q(dq)
  );

  assign r_clip = (dq > R_ONE) ? R_ONE : dq;

  // back stages: remaining ramp squared, times ramp distance
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_q <= dq;
      p1_rr <= (2*QW)'(r_clip) * (2*QW)'(r_clip);
      p2_q <= p1_q;
      p2_prod <= (2*QW)'(p1_rr[2*QW-2:QW-1]) * (2*QW)'(h);
      p3_pos <= pos_next;
      p3_seg <= seg_next;
    end
  end

  assign drop = p2_prod[2*QW-1:33];
  assign q_clip = (p2_q > QW'(tmprof_pkg::ONE_Q30)) ? tmprof_pkg::ONE_Q30 : POS_W'(p2_q);

  always_comb begin
    case (p2_ctl.kind)
      tmprof_pkg::KIND_ZERO: begin
        pos_next = '0;
        seg_next = tmprof_pkg::SEG_ACCEL;
      end
      tmprof_pkg::KIND_TRI_ACC, tmprof_pkg::KIND_TRAP_ACC: begin
        pos_next = q_clip;
        seg_next = tmprof_pkg::SEG_ACCEL;
      end
      tmprof_pkg::KIND_CRUISE: begin
        pos_next = q_clip;
        seg_next = tmprof_pkg::SEG_CRUISE;
      end
      tmprof_pkg::KIND_TRI_DEC: begin
        pos_next = (p2_q >= QW'(tmprof_pkg::ONE_Q30)) ? '0 :
                   tmprof_pkg::ONE_Q30 - POS_W'(p2_q);
        seg_next = tmprof_pkg::SEG_DECEL;
      end
      tmprof_pkg::KIND_TRAP_DEC: begin
        pos_next = (drop >= tmprof_pkg::ONE_Q30) ? '0 : tmprof_pkg::ONE_Q30 - drop;
        seg_next = tmprof_pkg::SEG_DECEL;
      end
      default: begin
        pos_next = tmprof_pkg::ONE_Q30;
        seg_next = tmprof_pkg::SEG_DONE;
      end
    endcase
  end

  assign result.valid = p3_vld;
  assign result.position_q30 = p3_pos;
  assign result.segment = p3_seg;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.position_q30 <= tmprof_pkg::ONE_Q30)
    else $error("position above one");

  a_done_at_one: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.segment == tmprof_pkg::SEG_DONE
      |-> result.position_q30 == tmprof_pkg::ONE_Q30)
    else $error("done segment not at one");

  a_cruise_trap: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.segment == tmprof_pkg::SEG_CRUISE |-> !tri_shape)
    else $error("cruise in triangular profile");

  a_no_req_busy: assert property (@(posedge clk) disable iff (rst)
    !cfg_rdy |=> !s1_vld || $past(!adv))
    else $error("request taken during settle");
`endif

endmodule

`default_nettype wire
